// File: src/pocc_pkg.sv
package pocc_pkg;

  // bank sizes
  localparam int unsigned RelayChannels  = 4;
  localparam int unsigned LowDcChannels  = 3;
  localparam int unsigned HighDcChannels = 1;

  // widest bank, working width of the mask update
  localparam int unsigned MaskW = 4;

  // variable output range in tenths of a volt
  localparam logic [5:0]  VarMinTenths = 6'd15;
  localparam logic [5:0]  VarMaxTenths = 6'd50;
  localparam logic [13:0] PwmWrap      = 14'd10000;

  // polarity code nibble of the dc word
  localparam logic [3:0] PolCodePos = 4'hA;
  localparam logic [3:0] PolCodeNeg = 4'h5;
  localparam logic [3:0] PolCodeOff = 4'h3;

  typedef enum logic [3:0] {
    OP_RELAY_SET = 4'd0,
    OP_RELAY_CLR = 4'd1,
    OP_LOW_SET   = 4'd2,
    OP_LOW_CLR   = 4'd3,
    OP_HIGH_SET  = 4'd4,
    OP_HIGH_CLR  = 4'd5,
    OP_POLARITY  = 4'd6,
    OP_VARIABLE  = 4'd7,
    OP_RESET     = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    POL_OFF = 2'd0,
    POL_POS = 2'd1,
    POL_NEG = 2'd2
  } polarity_e;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] channel;
    logic [1:0] polarity;
    logic [5:0] var_tenths;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic        relay_valid;
    logic [3:0]  relay_word;
    logic        dc_valid;
    logic [7:0]  dc_word;
    logic        duty_valid;
    logic [13:0] duty;
  } result_t;

  typedef struct packed {
    logic             ok;
    logic [MaskW-1:0] mask;
  } mask_upd_t;

  // set or clear one channel (1..count), or all of them for channel 0
  function automatic mask_upd_t mask_update(logic [MaskW-1:0] mask, logic [2:0] chan,
                                            logic set, int unsigned count);
    logic [MaskW-1:0] all_ch;
    logic [MaskW-1:0] sel;
    mask_upd_t        r;
    for (int unsigned i = 0; i < MaskW; i++) begin
      all_ch[i] = (i < count);
      sel[i]    = (chan == 3'(i + 1));
    end
    r.ok   = 1'b1;
    r.mask = mask;
    if (chan == 3'd0) begin
      r.mask = set ? all_ch : '0;
    end else if (32'(chan) > count) begin
      r.ok = 1'b0;
    end else if (set) begin
      r.mask = (mask | sel) & all_ch;
    end else begin
      r.mask = mask & ~sel & all_ch;
    end
    return r;
  endfunction

  // pwm compare level for (tenths - VarMinTenths)
  function automatic logic [13:0] duty_lookup(logic [5:0] idx);
    logic [13:0] d;
    case (idx)
      6'd0:  d = 14'd1280;
      6'd1:  d = 14'd1300;
      6'd2:  d = 14'd1320;
      6'd3:  d = 14'd1335;
      6'd4:  d = 14'd1350;
      6'd5:  d = 14'd1370;
      6'd6:  d = 14'd1385;
      6'd7:  d = 14'd1400;
      6'd8:  d = 14'd1420;
      6'd9:  d = 14'd1440;
      6'd10: d = 14'd1460;
      6'd11: d = 14'd1480;
      6'd12: d = 14'd1510;
      6'd13: d = 14'd1540;
      6'd14: d = 14'd1580;
      6'd15: d = 14'd1620;
      6'd16: d = 14'd1670;
      6'd17: d = 14'd1730;
      6'd18: d = 14'd1810;
      6'd19: d = 14'd1900;
      6'd20: d = 14'd2000;
      6'd21: d = 14'd2140;
      6'd22: d = 14'd2320;
      6'd23: d = 14'd2520;
      6'd24: d = 14'd2860;
      6'd25: d = 14'd3400;
      6'd26: d = 14'd3980;
      6'd27: d = 14'd4720;
      6'd28: d = 14'd5400;
      6'd29: d = 14'd6200;
      6'd30: d = 14'd6900;
      6'd31: d = 14'd7560;
      6'd32: d = 14'd8380;
      6'd33: d = 14'd9300;
      6'd34: d = 14'd10000;
      6'd35: d = 14'd10000;
      default: d = 14'd0;
    endcase
    return d;
  endfunction

endpackage

// File: src/power_outlet_channel_controller.sv
// power outlet channel controller: relay, 3v3, 5v masks, polarity and variable pwm duty
// command registered on accept, result registered from it once the result slot frees
// throughput: one transaction per cycle, set by the single compute stage between the
//   command register and the result register; a stalled result holds the compute stage
// reset (rst_ni low, async): all masks cleared, polarity off, both stages empty
module power_outlet_channel_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pocc_pkg::cmd_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pocc_pkg::result_t out_data_o
);
  import pocc_pkg::*;

  // command register
  logic in_valid_q;
  cmd_t cmd_q;

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  // channel state
  logic [RelayChannels-1:0]  relay_q,  relay_d;
  logic [LowDcChannels-1:0]  low_dc_q, low_dc_d;
  logic [HighDcChannels-1:0] high_dc_q, high_dc_d;
  logic [1:0]                pol_q,    pol_d;

  logic      advance;   // compute stage moves into the result register
  logic      fire;      // a command is processed this cycle
  mask_upd_t upd;
  logic [3:0] pol_code;

  // result slot frees when empty or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    relay_d   = relay_q;
    low_dc_d  = low_dc_q;
    high_dc_d = high_dc_q;
    pol_d     = pol_q;
    res_d     = '0;
    upd       = '0;

    case (cmd_q.opcode)
      OP_RELAY_SET, OP_RELAY_CLR: begin
        upd = mask_update(MaskW'(relay_q), cmd_q.channel,
                          cmd_q.opcode == OP_RELAY_SET, RelayChannels);
        relay_d           = upd.mask[RelayChannels-1:0];
        res_d.ok          = upd.ok;
        res_d.relay_valid = upd.ok;
      end
      OP_LOW_SET, OP_LOW_CLR: begin
        upd = mask_update(MaskW'(low_dc_q), cmd_q.channel,
                          cmd_q.opcode == OP_LOW_SET, LowDcChannels);
        low_dc_d       = upd.mask[LowDcChannels-1:0];
        res_d.ok       = upd.ok;
        res_d.dc_valid = upd.ok;
      end
      OP_HIGH_SET, OP_HIGH_CLR: begin
        upd = mask_update(MaskW'(high_dc_q), cmd_q.channel,
                          cmd_q.opcode == OP_HIGH_SET, HighDcChannels);
        high_dc_d      = upd.mask[HighDcChannels-1:0];
        res_d.ok       = upd.ok;
        res_d.dc_valid = upd.ok;
      end
      OP_POLARITY: begin
        // undefined code is rejected, state untouched
        if (cmd_q.polarity <= POL_NEG) begin
          pol_d          = cmd_q.polarity;
          res_d.ok       = 1'b1;
          res_d.dc_valid = 1'b1;
        end
      end
      OP_VARIABLE: begin
        // out-of-range tenths still apply duty 0, but flag the command
        res_d.duty_valid = 1'b1;
        if (cmd_q.var_tenths == 6'd0) begin
          res_d.ok = 1'b1;
        end else if (cmd_q.var_tenths >= VarMinTenths &&
                     cmd_q.var_tenths <= VarMaxTenths) begin
          res_d.ok   = 1'b1;
          res_d.duty = duty_lookup(cmd_q.var_tenths - VarMinTenths);
        end
      end
      OP_RESET: begin
        relay_d           = '0;
        low_dc_d          = '0;
        high_dc_d         = '0;
        pol_d             = POL_OFF;
        res_d.ok          = 1'b1;
        res_d.relay_valid = 1'b1;
        res_d.dc_valid    = 1'b1;
        res_d.duty_valid  = 1'b1;
      end
      default: begin
        // unused opcodes: flagged, nothing sent
      end
    endcase

    // words are packed from the updated state
    case (pol_d)
      POL_POS: pol_code = PolCodePos;
      POL_NEG: pol_code = PolCodeNeg;
      default: pol_code = PolCodeOff;
    endcase

    if (res_d.relay_valid) begin
      res_d.relay_word = 4'(relay_d);
    end
    if (res_d.dc_valid) begin
      res_d.dc_word = {pol_code, high_dc_d[0], 3'(low_dc_d)};
    end
    if (res_d.duty > PwmWrap) begin
      res_d.duty = PwmWrap;
    end
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      relay_q     <= '0;
      low_dc_q    <= '0;
      high_dc_q   <= '0;
      pol_q       <= POL_OFF;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        relay_q   <= relay_d;
        low_dc_q  <= low_dc_d;
        high_dc_q <= high_dc_d;
        pol_q     <= pol_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

// File: src/pocc_checker.sv
module pocc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pocc_pkg::result_t out_data_o
);
  import pocc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // words not sent read as zero
  a_unsent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.relay_valid || out_data_o.relay_word == 4'd0) &&
                    (out_data_o.dc_valid || out_data_o.dc_word == 8'd0) &&
                    (out_data_o.duty_valid || out_data_o.duty == 14'd0))
    else $error("unsent word not zero");

  // dc word carries a legal polarity code
  a_dc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dc_valid |->
      out_data_o.dc_word[7:4] == PolCodePos || out_data_o.dc_word[7:4] == PolCodeNeg ||
      out_data_o.dc_word[7:4] == PolCodeOff)
    else $error("bad polarity code");

  // duty never beyond the pwm wrap
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty <= PwmWrap)
    else $error("duty above wrap");

  // a flagged command sends no relay or dc word
  a_flag_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> !out_data_o.relay_valid && !out_data_o.dc_valid)
    else $error("word sent for flagged command");

endmodule

bind power_outlet_channel_controller pocc_checker u_pocc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: verif/tb_power_outlet_channel_controller.sv
`timescale 1ns / 100ps

module tb_power_outlet_channel_controller;
  import pocc_pkg::*;

  // clocking and run length
  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned ResetCycles = 4;
  localparam int unsigned RandomCmds  = 700;
  localparam int unsigned CycleLimit  = 200000;
  // pipeline is two stages deep, drain with margin past that
  localparam int unsigned DrainCycles = 8;

  // random phase landmarks: one full drain, one stretch with no gaps
  localparam int unsigned HoldItem  = 350;
  localparam int unsigned CalmFirst = 500;
  localparam int unsigned CalmLast  = 580;

  // codes outside the defined sets
  localparam logic [3:0] OpUnusedFirst = 4'd9;
  localparam logic [3:0] OpUnusedLast  = 4'd15;
  localparam logic [1:0] PolUndefined  = 2'd3;

  // pwm compare level per tenth of a volt, starting at the minimum setting
  localparam logic [13:0] DutyLut [36] = '{
    14'd1280, 14'd1300, 14'd1320, 14'd1335, 14'd1350, 14'd1370, 14'd1385, 14'd1400,
    14'd1420, 14'd1440, 14'd1460, 14'd1480, 14'd1510, 14'd1540, 14'd1580, 14'd1620,
    14'd1670, 14'd1730, 14'd1810, 14'd1900, 14'd2000, 14'd2140, 14'd2320, 14'd2520,
    14'd2860, 14'd3400, 14'd3980, 14'd4720, 14'd5400, 14'd6200, 14'd6900, 14'd7560,
    14'd8380, 14'd9300, 14'd10000, 14'd10000
  };

  // one row of the directed table
  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t res;
  } dir_row_t;

  // dut hookup
  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  cmd_t    in_cmd    = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_res;

  // typed expectation that rides along with the command on the bus
  bit      cur_typed     = 1'b0;
  result_t cur_typed_res = '0;

  // shadow copy of the outlet state
  logic [MaskW-1:0] relay_q = '0;
  logic [MaskW-1:0] low_q   = '0;
  logic [MaskW-1:0] high_q  = '0;
  polarity_e        pol_q   = POL_OFF;

  result_t     pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          calm        = 1'b0;

  power_outlet_channel_controller DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_cmd),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_res)
  );

  always #(ClkHalf) clk = ~clk;

  // set or clear one channel of a bank, or the whole bank for channel 0
  function automatic logic [MaskW-1:0] apply_mask(input logic [MaskW-1:0] mask,
                                                  input int unsigned count,
                                                  input logic [2:0] chan, input bit set,
                                                  output bit ok);
    logic [MaskW-1:0] full;
    logic [MaskW-1:0] bitsel;
    full = MaskW'((1 << count) - 1);
    ok   = 1'b1;
    if (chan == 3'd0) return set ? full : '0;
    if (int'(chan) > count) begin
      // channel beyond the bank, leave the mask alone
      ok = 1'b0;
      return mask;
    end
    bitsel = MaskW'(1 << (chan - 1));
    return set ? ((mask | bitsel) & full) : (mask & ~bitsel & full);
  endfunction

  // advance the shadow state by one command and build its result
  function automatic result_t predict_result(input cmd_t c);
    result_t    r;
    bit         ok_m;
    logic [3:0] code;
    r = '0;
    case (c.opcode)
      OP_RELAY_SET, OP_RELAY_CLR: begin
        relay_q = apply_mask(relay_q, RelayChannels, c.channel, c.opcode == OP_RELAY_SET, ok_m);
        r.ok = ok_m;
        r.relay_valid = ok_m;
      end
      OP_LOW_SET, OP_LOW_CLR: begin
        low_q = apply_mask(low_q, LowDcChannels, c.channel, c.opcode == OP_LOW_SET, ok_m);
        r.ok = ok_m;
        r.dc_valid = ok_m;
      end
      OP_HIGH_SET, OP_HIGH_CLR: begin
        high_q = apply_mask(high_q, HighDcChannels, c.channel, c.opcode == OP_HIGH_SET, ok_m);
        r.ok = ok_m;
        r.dc_valid = ok_m;
      end
      OP_POLARITY: begin
        // undefined polarity code is refused with nothing sent
        if (c.polarity != PolUndefined) begin
          pol_q = polarity_e'(c.polarity);
          r.ok = 1'b1;
          r.dc_valid = 1'b1;
        end
      end
      OP_VARIABLE: begin
        // duty always applies; out of range settings force it to zero
        r.duty_valid = 1'b1;
        if (c.var_tenths == '0) begin
          r.ok = 1'b1;
        end else if (c.var_tenths >= VarMinTenths && c.var_tenths <= VarMaxTenths) begin
          r.duty = DutyLut[c.var_tenths - VarMinTenths];
          r.ok = 1'b1;
        end
      end
      OP_RESET: begin
        relay_q = '0;
        low_q   = '0;
        high_q  = '0;
        pol_q   = POL_OFF;
        r.ok = 1'b1;
        r.relay_valid = 1'b1;
        r.dc_valid = 1'b1;
        r.duty_valid = 1'b1;
      end
      default: begin
        // unused opcode, nothing happens
      end
    endcase
    case (pol_q)
      POL_POS: code = PolCodePos;
      POL_NEG: code = PolCodeNeg;
      default: code = PolCodeOff;
    endcase
    if (r.relay_valid) r.relay_word = relay_q;
    if (r.dc_valid) r.dc_word = {code, high_q[0], low_q[2:0]};
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [3:0] op, input logic [2:0] chan,
                                  input logic [1:0] pol, input logic [5:0] tenths);
    cmd_t c;
    c.opcode     = op;
    c.channel    = chan;
    c.polarity   = pol;
    c.var_tenths = tenths;
    return c;
  endfunction

  function automatic result_t mk_res(input logic ok, input logic rv, input logic [3:0] rw,
                                     input logic dv, input logic [7:0] dw, input logic pv,
                                     input logic [13:0] duty);
    result_t r;
    r.ok          = ok;
    r.relay_valid = rv;
    r.relay_word  = rw;
    r.dc_valid    = dv;
    r.dc_word     = dw;
    r.duty_valid  = pv;
    r.duty        = duty;
    return r;
  endfunction

  function automatic void add_row(input cmd_t c, input bit typed, input result_t r);
    dir_row_t row;
    row.cmd   = c;
    row.typed = typed;
    row.res   = r;
    dir_rows.push_back(row);
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random command, biased toward channels inside the bank and defined settings
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned r;
    int unsigned bank;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      c.opcode = OP_RESET;
    end else if (r < 10) begin
      c.opcode = OpUnusedFirst + 4'($urandom_range(0, int'(OpUnusedLast - OpUnusedFirst)));
    end else begin
      c.opcode = 4'($urandom_range(int'(OP_RELAY_SET), int'(OP_VARIABLE)));
    end
    case (c.opcode)
      OP_RELAY_SET, OP_RELAY_CLR: bank = RelayChannels;
      OP_LOW_SET, OP_LOW_CLR:     bank = LowDcChannels;
      OP_HIGH_SET, OP_HIGH_CLR:   bank = HighDcChannels;
      default:                    bank = 7;
    endcase
    c.channel = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, bank))
                                              : 3'($urandom_range(0, 7));
    c.polarity = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(int'(POL_OFF), int'(POL_NEG)))
                                               : 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c.var_tenths = 6'($urandom_range(int'(VarMinTenths), int'(VarMaxTenths)));
    end else if (r < 70) begin
      c.var_tenths = '0;
    end else begin
      c.var_tenths = 6'($urandom);
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result(input result_t exp_r, input result_t act_r);
    check_field("ok", 32'(exp_r.ok), 32'(act_r.ok));
    check_field("relay_valid", 32'(exp_r.relay_valid), 32'(act_r.relay_valid));
    check_field("relay_word", 32'(exp_r.relay_word), 32'(act_r.relay_word));
    check_field("dc_valid", 32'(exp_r.dc_valid), 32'(act_r.dc_valid));
    check_field("dc_word", 32'(exp_r.dc_word), 32'(act_r.dc_word));
    check_field("duty_valid", 32'(exp_r.duty_valid), 32'(act_r.duty_valid));
    check_field("duty", 32'(exp_r.duty), 32'(act_r.duty));
  endtask

  // present one command after an optional gap, return once it is accepted
  task automatic send_cmd(input cmd_t c, input bit typed, input result_t res);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    cur_typed     <= typed;
    cur_typed_res <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait with valid low until every result in flight has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    // wait for an edge first so the last accepted command is already queued
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side back pressure, none during the calm stretch
  always @(posedge clk) begin : result_stall
    int unsigned n;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      n = pick_gap();
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = n - 1;
      end
    end
  end

  // predict on every accepted command, check every accepted result in order
  always @(posedge clk) begin : scoreboard
    result_t predicted;
    result_t oldest;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        // the shadow state always advances, typed rows override the value kept
        predicted = predict_result(in_cmd);
        pending_results.push_back(cur_typed ? cur_typed_res : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no command pending: %h", out_res);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_result(oldest, out_res);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // directed table: typed results only where the value is plain
    add_row(mk_cmd(OP_RELAY_CLR, 3'd1, POL_OFF, 6'd0), 1'b1,
            mk_res(1'b1, 1'b1, 4'h0, 1'b0, 8'h00, 1'b0, 14'd0));
    add_row(mk_cmd(OP_RELAY_SET, 3'd0, POL_OFF, 6'd0), 1'b1,
            mk_res(1'b1, 1'b1, 4'hF, 1'b0, 8'h00, 1'b0, 14'd0));
    add_row(mk_cmd(OP_RELAY_CLR, 3'd3, POL_OFF, 6'd0), 1'b0, '0);
    // channel beyond the relay bank
    add_row(mk_cmd(OP_RELAY_SET, 3'd5, POL_OFF, 6'd0), 1'b1, '0);
    add_row(mk_cmd(OP_RELAY_SET, 3'd7, POL_NEG, 6'd63), 1'b1, '0);
    add_row(mk_cmd(OP_LOW_SET, 3'd0, POL_OFF, 6'd0), 1'b1,
            mk_res(1'b1, 1'b0, 4'h0, 1'b1, {PolCodeOff, 4'h7}, 1'b0, 14'd0));
    add_row(mk_cmd(OP_LOW_CLR, 3'd2, POL_OFF, 6'd0), 1'b0, '0);
    add_row(mk_cmd(OP_LOW_SET, 3'd4, POL_OFF, 6'd0), 1'b1, '0);
    add_row(mk_cmd(OP_HIGH_SET, 3'd1, POL_OFF, 6'd0), 1'b0, '0);
    add_row(mk_cmd(OP_HIGH_SET, 3'd2, POL_OFF, 6'd0), 1'b1, '0);
    add_row(mk_cmd(OP_POLARITY, 3'd0, POL_POS, 6'd0), 1'b0, '0);
    add_row(mk_cmd(OP_POLARITY, 3'd7, POL_NEG, 6'd0), 1'b0, '0);
    // undefined polarity code
    add_row(mk_cmd(OP_POLARITY, 3'd0, PolUndefined, 6'd0), 1'b1, '0);
    add_row(mk_cmd(OP_POLARITY, 3'd0, POL_OFF, 6'd0), 1'b0, '0);
    add_row(mk_cmd(OP_HIGH_CLR, 3'd0, POL_OFF, 6'd0), 1'b0, '0);
    // variable output: off, below range, both ends, above range
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, 6'd0), 1'b1,
            mk_res(1'b1, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, 14'd0));
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, 6'd1), 1'b1,
            mk_res(1'b0, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, 14'd0));
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, VarMinTenths - 6'd1), 1'b1,
            mk_res(1'b0, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, 14'd0));
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, VarMinTenths), 1'b1,
            mk_res(1'b1, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, 14'd1280));
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, VarMaxTenths), 1'b1,
            mk_res(1'b1, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, PwmWrap));
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, VarMaxTenths + 6'd1), 1'b1,
            mk_res(1'b0, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, 14'd0));
    add_row(mk_cmd(OP_VARIABLE, 3'd7, PolUndefined, 6'd63), 1'b1,
            mk_res(1'b0, 1'b0, 4'h0, 1'b0, 8'h00, 1'b1, 14'd0));
    add_row(mk_cmd(OP_VARIABLE, 3'd0, POL_OFF, 6'd32), 1'b0, '0);
    // unused opcodes do nothing
    add_row(mk_cmd(OpUnusedFirst, 3'd0, POL_POS, 6'd20), 1'b1, '0);
    add_row(mk_cmd(OpUnusedLast, 3'd7, PolUndefined, 6'd63), 1'b1, '0);
    // reset command sends everything cleared
    add_row(mk_cmd(OP_RESET, 3'd0, POL_OFF, 6'd0), 1'b1,
            mk_res(1'b1, 1'b1, 4'h0, 1'b1, {PolCodeOff, 4'h0}, 1'b1, 14'd0));

    // single reset at the start
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    hold_until_drained();

    for (int i = 0; i < RandomCmds; i++) begin
      calm = (i >= CalmFirst && i < CalmLast);
      // sender pause until everything in flight has returned
      if (i == HoldItem) hold_until_drained();
      send_cmd(rand_cmd(), 1'b0, '0);
    end
    calm = 1'b0;

    // drain and let the pipeline settle
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
